// ----- rtl/bmms_pkg.sv -----
// Shared constants for the Beaver triple multiplication share block.
`default_nettype none
package bmms_pkg;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRIME = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PARTY = 1'b1;
  localparam logic [63:0] PRIME_RESET = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam int IN_LANES = 7;
  localparam int MUL_LANES = 3;
endpackage
`default_nettype wire

// ----- rtl/beaver_modular_multiply_share.sv -----
// Throughput: one item per cycle while the output is not stalled.
// Input reduction takes one bit per stage (VALUE_BITS stages), then two stages for the
// masked values, VALUE_BITS shift-and-add stages for the three products, two to combine.
// The whole pipe holds while the output is stalled; bubbles are not squeezed out.
// Synchronous reset clears the valid bits and loads modulus 2^61-1 and party 0.
`default_nettype none
module beaver_modular_multiply_share
  import bmms_pkg::*;
#(
  parameter int VALUE_BITS = 63
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [VALUE_BITS-1:0]     cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [VALUE_BITS-1:0]     x_share,
  input  wire logic [VALUE_BITS-1:0]     y_share,
  input  wire logic [VALUE_BITS-1:0]     triple_a,
  input  wire logic [VALUE_BITS-1:0]     triple_b,
  input  wire logic [VALUE_BITS-1:0]     triple_c,
  input  wire logic [VALUE_BITS-1:0]     peer_d,
  input  wire logic [VALUE_BITS-1:0]     peer_e,
  input  wire logic                      last_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [VALUE_BITS-1:0]          own_d,
  output logic [VALUE_BITS-1:0]          own_e,
  output logic [VALUE_BITS-1:0]          product_share,
  output logic                           last_out
);
  localparam int W = VALUE_BITS;
  localparam int L = 2 * W + 4;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W-1:0] d;
    d = a - b;
    if (a < b) d = d + m;
    return d;
  endfunction

  function automatic logic [W-1:0] dbl_bit(input logic [W-1:0] r, input logic bit_in,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {r, bit_in};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mul_step(input logic [W-1:0] acc, input logic [W-1:0] a,
                                            input logic bit_in, input logic [W-1:0] m);
    logic [W-1:0] t;
    t = add_mod(acc, acc, m);
    if (bit_in) t = add_mod(t, a, m);
    return t;
  endfunction

  // configuration
  logic [W-1:0] prime_modulus;
  logic         party_index;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus <= W'(PRIME_RESET);
      party_index   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIME: prime_modulus <= cfg_data;
        CFG_PARTY: party_index   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [L-1:0] vld;
  logic         adv;

  assign adv      = !(vld[L-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // input reduction, one bit per stage
  logic [W-1:0] in_vals [0:IN_LANES-1];
  logic [W-1:0] rd_rem  [1:W][0:IN_LANES-1];
  logic [W-1:0] rd_raw  [1:W][0:IN_LANES-1];
  logic         rd_last [1:W];

  assign in_vals[0] = x_share;
  assign in_vals[1] = y_share;
  assign in_vals[2] = triple_a;
  assign in_vals[3] = triple_b;
  assign in_vals[4] = triple_c;
  assign in_vals[5] = peer_d;
  assign in_vals[6] = peer_e;

  for (genvar k = 0; k < W; k++) begin : g_red
    for (genvar j = 0; j < IN_LANES; j++) begin : g_lane
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            rd_rem[1][j] <= dbl_bit('0, in_vals[j][W-1], prime_modulus);
            rd_raw[1][j] <= in_vals[j] << 1;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv) begin
            rd_rem[k+1][j] <= dbl_bit(rd_rem[k][j], rd_raw[k][j][W-1], prime_modulus);
            rd_raw[k+1][j] <= rd_raw[k][j] << 1;
          end
        end
      end
    end
    if (k == 0) begin : g_last0
      always_ff @(posedge clk) begin
        if (adv) rd_last[1] <= last_in;
      end
    end else begin : g_lastn
      always_ff @(posedge clk) begin
        if (adv) rd_last[k+1] <= rd_last[k];
      end
    end
  end

  // masked shares
  logic [W-1:0] m1_x, m1_y, m1_c, m1_pd, m1_pe, m1_od, m1_oe;
  logic         m1_last;
  logic [W-1:0] m2_x, m2_y, m2_c, m2_od, m2_oe, m2_d, m2_e;
  logic         m2_last;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_x    <= rd_rem[W][0];
      m1_y    <= rd_rem[W][1];
      m1_c    <= rd_rem[W][4];
      m1_pd   <= rd_rem[W][5];
      m1_pe   <= rd_rem[W][6];
      m1_od   <= sub_mod(rd_rem[W][0], rd_rem[W][2], prime_modulus);
      m1_oe   <= sub_mod(rd_rem[W][1], rd_rem[W][3], prime_modulus);
      m1_last <= rd_last[W];
      m2_x    <= m1_x;
      m2_y    <= m1_y;
      m2_c    <= m1_c;
      m2_od   <= m1_od;
      m2_oe   <= m1_oe;
      m2_d    <= add_mod(m1_od, m1_pd, prime_modulus);
      m2_e    <= add_mod(m1_oe, m1_pe, prime_modulus);
      m2_last <= m1_last;
    end
  end

  // products x*e, y*d, d*e: one multiplier bit per stage, MSB first
  logic [W-1:0] mu_src_a [0:MUL_LANES-1];
  logic [W-1:0] mu_src_b [0:MUL_LANES-1];
  logic [W-1:0] mu_acc   [1:W][0:MUL_LANES-1];
  logic [W-1:0] mu_a     [1:W][0:MUL_LANES-1];
  logic [W-1:0] mu_b     [1:W][0:MUL_LANES-1];
  logic [W-1:0] mu_c     [1:W];
  logic [W-1:0] mu_od    [1:W];
  logic [W-1:0] mu_oe    [1:W];
  logic         mu_last  [1:W];

  assign mu_src_a[0] = m2_x;
  assign mu_src_b[0] = m2_e;
  assign mu_src_a[1] = m2_y;
  assign mu_src_b[1] = m2_d;
  assign mu_src_a[2] = m2_d;
  assign mu_src_b[2] = m2_e;

  for (genvar k = 0; k < W; k++) begin : g_mul
    for (genvar j = 0; j < MUL_LANES; j++) begin : g_lane
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            mu_acc[1][j] <= mul_step('0, mu_src_a[j], mu_src_b[j][W-1], prime_modulus);
            mu_a[1][j]   <= mu_src_a[j];
            mu_b[1][j]   <= mu_src_b[j] << 1;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv) begin
            mu_acc[k+1][j] <= mul_step(mu_acc[k][j], mu_a[k][j], mu_b[k][j][W-1],
                                       prime_modulus);
            mu_a[k+1][j]   <= mu_a[k][j];
            mu_b[k+1][j]   <= mu_b[k][j] << 1;
          end
        end
      end
    end
    if (k == 0) begin : g_side0
      always_ff @(posedge clk) begin
        if (adv) begin
          mu_c[1]    <= m2_c;
          mu_od[1]   <= m2_od;
          mu_oe[1]   <= m2_oe;
          mu_last[1] <= m2_last;
        end
      end
    end else begin : g_siden
      always_ff @(posedge clk) begin
        if (adv) begin
          mu_c[k+1]    <= mu_c[k];
          mu_od[k+1]   <= mu_od[k];
          mu_oe[k+1]   <= mu_oe[k];
          mu_last[k+1] <= mu_last[k];
        end
      end
    end
  end

  // combine
  logic [W-1:0] f1_z, f1_de, f1_od, f1_oe;
  logic         f1_last;
  logic         no_field;

  assign no_field = (prime_modulus < W'(2));

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_z    <= add_mod(add_mod(mu_c[W], mu_acc[W][0], prime_modulus), mu_acc[W][1],
                         prime_modulus);
      f1_de   <= mu_acc[W][2];
      f1_od   <= mu_od[W];
      f1_oe   <= mu_oe[W];
      f1_last <= mu_last[W];
      last_out <= f1_last;
      if (no_field) begin
        own_d         <= '0;
        own_e         <= '0;
        product_share <= '0;
      end else begin
        own_d         <= f1_od;
        own_e         <= f1_oe;
        product_share <= party_index ? f1_z : sub_mod(f1_z, f1_de, prime_modulus);
      end
    end
  end

  // checks
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item did not enter the pipe");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[L-1] && out_stall |=> $stable(vld))
    else $error("pipe moved during output stall");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule
`default_nettype wire
